// File: hw/rtl/opsr_pkg.sv
// ----------------------------------------------------------------------------
// opsr_pkg
// Shared constants, codes and handshake structs for the shift-reduce parser.
// ----------------------------------------------------------------------------
package opsr_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int MAX_TERM_DEF    = 10;
    localparam int MAX_RESULTS     = 64;

    localparam int SYM_W     = 8;
    localparam int ACT_W     = 3;
    localparam int DOUT_W    = 6;
    localparam int TIDX_W    = 4;
    localparam int CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 60;
    localparam int TCNT_W    = 4;
    localparam int SYMS_W    = 40;
    localparam int RELW_W    = 60;
    localparam int ROW_W     = 30;
    localparam int REL_WORDS = 5;
    localparam int OUT_TDATA_W = 24;

    localparam logic [SYM_W-1:0] CH_DOLLAR = 8'h24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMS_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMS_SECOND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_01 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_23 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_45 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_67 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_89 = 3'd7;

    // precedence relation codes
    localparam logic [2:0] REL_LT      = 3'd0;
    localparam logic [2:0] REL_EQ      = 3'd1;
    localparam logic [2:0] REL_GT      = 3'd2;
    localparam logic [2:0] REL_ACC     = 3'd3;
    localparam logic [2:0] REL_INVALID = 3'd7;

    typedef enum logic [ACT_W-1:0] {
        ACT_SHIFT  = 3'd0,
        ACT_REDUCE = 3'd1,
        ACT_ACCEPT = 3'd2,
        ACT_BAD    = 3'd3,
        ACT_OVER   = 3'd4,
        ACT_UNDER  = 3'd5
    } act_t;

    typedef struct packed {
        logic load;   // take the input word
        logic find;   // register terminal indexes
        logic step;   // run one shift-reduce step
    } opsr_cmd_t;

    typedef struct packed {
        logic skip;     // string finished, input word drops without results
        logic out_free; // result register can take a word
        logic more;     // another step follows for this input word
    } opsr_sts_t;

endpackage

// File: hw/rtl/opsr_cfg.sv
// ----------------------------------------------------------------------------
// opsr_cfg
// Configuration registers, terminal lookup and precedence table read.
// ----------------------------------------------------------------------------
module opsr_cfg
    import opsr_pkg::*;
#(
    parameter int MAX_TERMINALS = MAX_TERM_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic [SYM_W-1:0]     top_sym,
    input  logic [SYM_W-1:0]     cur_sym,
    output logic                 row_hit,
    output logic [TIDX_W-1:0]    row_idx,
    output logic                 col_hit,
    output logic [TIDX_W-1:0]    col_idx,
    input  logic [TIDX_W-1:0]    row_sel,
    input  logic [TIDX_W-1:0]    col_sel,
    output logic [2:0]           rel_code
);

    logic [TCNT_W-1:0] term_count_reg;
    logic [SYMS_W-1:0] syms_first_reg;
    logic [SYMS_W-1:0] syms_second_reg;
    logic [RELW_W-1:0] rel_reg [REL_WORDS];

    logic [2*SYMS_W-1:0] syms;
    logic [TCNT_W-1:0]   n_eff;
    logic [RELW_W-1:0]   rel_word;
    logic [ROW_W-1:0]    rel_row;
    logic [4:0]          col_base;

    function automatic logic [TIDX_W:0] find_term(
        input logic [SYM_W-1:0]    sym,
        input logic [2*SYMS_W-1:0] tab,
        input logic [TCNT_W-1:0]   n
    );
        logic              hit;
        logic [TIDX_W-1:0] idx;
        hit = 1'b0;
        idx = '0;
        // walk downwards so the lowest matching slot wins
        for (int i = MAX_TERMINALS - 1; i >= 0; i--)
        begin
            if ((TCNT_W'(i) < n) && (tab[SYM_W*i +: SYM_W] == sym))
            begin
                hit = 1'b1;
                idx = TIDX_W'(i);
            end
        end
        return {hit, idx};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg  <= '0;
            syms_first_reg  <= '0;
            syms_second_reg <= '0;
            for (int w = 0; w < REL_WORDS; w++)
            begin
                rel_reg[w] <= '1;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TERM_COUNT:  term_count_reg  <= cfg_data[TCNT_W-1:0];
                CFG_SYMS_FIRST:  syms_first_reg  <= cfg_data[SYMS_W-1:0];
                CFG_SYMS_SECOND: syms_second_reg <= cfg_data[SYMS_W-1:0];
                CFG_REL_01:      rel_reg[0]      <= cfg_data[RELW_W-1:0];
                CFG_REL_23:      rel_reg[1]      <= cfg_data[RELW_W-1:0];
                CFG_REL_45:      rel_reg[2]      <= cfg_data[RELW_W-1:0];
                CFG_REL_67:      rel_reg[3]      <= cfg_data[RELW_W-1:0];
                CFG_REL_89:      rel_reg[4]      <= cfg_data[RELW_W-1:0];
                default:         ;
            endcase
        end
    end

    assign syms  = {syms_second_reg, syms_first_reg};
    assign n_eff = (term_count_reg > TCNT_W'(MAX_TERMINALS)) ?
                   TCNT_W'(MAX_TERMINALS) : term_count_reg;

    assign {row_hit, row_idx} = find_term(top_sym, syms, n_eff);
    assign {col_hit, col_idx} = find_term(cur_sym, syms, n_eff);

    // even row in the low half of a word, odd row in the high half
    assign rel_word = rel_reg[row_sel[TIDX_W-1:1]];
    assign rel_row  = row_sel[0] ? rel_word[RELW_W-1:ROW_W] : rel_word[ROW_W-1:0];
    assign col_base = 5'(col_sel) * 5'd3;
    assign rel_code = rel_row[col_base +: 3];

endmodule

// File: hw/rtl/opsr_ctrl.sv
// ----------------------------------------------------------------------------
// opsr_ctrl
// Sequencer: take a word, then alternate lookup and step until it is done.
// ----------------------------------------------------------------------------
module opsr_ctrl
    import opsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  opsr_sts_t sts,
    output opsr_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_FIND = 3'b010,
        ST_STEP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (!sts.skip)
                    begin
                        state_next = ST_FIND;
                    end
                end
            end
            ST_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                // hold until the result register is free
                if (sts.out_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = sts.more ? ST_FIND : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/opsr_dp.sv
// ----------------------------------------------------------------------------
// opsr_dp
// Datapath: symbol stack, step decision and the result register.
// ----------------------------------------------------------------------------
module opsr_dp
    import opsr_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  opsr_cmd_t              cmd,
    output opsr_sts_t              sts,
    input  logic [SYM_W-1:0]       in_symbol,
    input  logic                   first_of_string,
    input  logic                   last_of_string,
    output logic [SYM_W-1:0]       top_sym,
    output logic [SYM_W-1:0]       cur_sym,
    input  logic                   row_hit,
    input  logic [TIDX_W-1:0]      row_idx,
    input  logic                   col_hit,
    input  logic [TIDX_W-1:0]      col_idx,
    output logic [TIDX_W-1:0]      row_sel,
    output logic [TIDX_W-1:0]      col_sel,
    input  logic [2:0]             rel_code,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEP_W = $clog2(STACK_DEPTH + 1);

    logic [SYM_W-1:0] stack_mem [STACK_DEPTH];

    logic [SYM_W-1:0]  top_reg;
    logic [DEP_W-1:0]  depth_reg;
    logic              finished_reg;
    logic [SYM_W-1:0]  cur_reg;
    logic              pend_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              row_hit_reg;
    logic              col_hit_reg;
    logic [TIDX_W-1:0] row_idx_reg;
    logic [TIDX_W-1:0] col_idx_reg;

    logic              out_valid_reg;
    act_t              out_act_reg;
    logic [SYM_W-1:0]  out_sym_reg;
    logic [DOUT_W-1:0] out_depth_reg;
    logic              out_last_reg;

    logic [2:0]        code_eff;
    logic [CNT_W-1:0]  limit;
    logic [CNT_W:0]    cnt_p1;
    logic [CNT_W:0]    cnt_p2;
    logic              full;
    act_t              act;
    logic [SYM_W-1:0]  act_sym;
    logic              do_push;
    logic              do_pop;
    logic              do_fin;
    logic              run_end;
    logic [DEP_W-1:0]  depth_next;
    logic [DEP_W-1:0]  depth_m2;

    assign top_sym = top_reg;
    assign cur_sym = cur_reg;
    assign row_sel = row_idx_reg;
    assign col_sel = col_idx_reg;

    assign code_eff = (row_hit_reg && col_hit_reg) ? rel_code : REL_INVALID;
    assign limit    = CNT_W'(MAX_RESULTS) - CNT_W'(pend_reg);
    assign cnt_p1   = {1'b0, cnt_reg} + (CNT_W+1)'(1);
    assign cnt_p2   = {1'b0, cnt_reg} + (CNT_W+1)'(2);
    assign full     = depth_reg >= DEP_W'(STACK_DEPTH);
    assign depth_m2 = depth_reg - DEP_W'(2);

    always_comb
    begin
        act     = ACT_BAD;
        act_sym = cur_reg;
        do_push = 1'b0;
        do_pop  = 1'b0;
        do_fin  = 1'b0;
        priority if ((top_reg == CH_DOLLAR) && (cur_reg == CH_DOLLAR))
        begin
            act    = ACT_ACCEPT;
            do_fin = 1'b1;
        end
        else if ((code_eff == REL_LT) || (code_eff == REL_EQ))
        begin
            if (full || (cnt_p1 > {1'b0, limit}))
            begin
                act    = ACT_OVER;
                do_fin = 1'b1;
            end
            else
            begin
                act     = ACT_SHIFT;
                do_push = 1'b1;
            end
        end
        else if (code_eff == REL_GT)
        begin
            if (depth_reg <= DEP_W'(1))
            begin
                act     = ACT_UNDER;
                act_sym = top_reg;
                do_fin  = 1'b1;
            end
            else if (cnt_p2 > {1'b0, limit})
            begin
                act    = ACT_OVER;
                do_fin = 1'b1;
            end
            else
            begin
                act     = ACT_REDUCE;
                act_sym = top_reg;
                do_pop  = 1'b1;
            end
        end
        else if (code_eff == REL_ACC)
        begin
            act    = ACT_ACCEPT;
            do_fin = 1'b1;
        end
        else
        begin
            act    = ACT_BAD;
            do_fin = 1'b1;
        end
    end

    assign run_end    = !do_pop;
    assign depth_next = depth_reg + DEP_W'(do_push) - DEP_W'(do_pop);

    assign sts.skip     = !first_of_string && finished_reg;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign sts.more     = do_pop || (run_end && !do_fin && pend_reg);

    // stack body, written only by a shift
    always_ff @(posedge clk)
    begin
        if (cmd.step && do_push)
        begin
            stack_mem[depth_reg[IDX_W-1:0]] <= cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg      <= CH_DOLLAR;
            depth_reg    <= DEP_W'(1);
            finished_reg <= 1'b0;
            pend_reg     <= 1'b0;
            cnt_reg      <= '0;
        end
        else if (cmd.load)
        begin
            if (first_of_string)
            begin
                top_reg      <= CH_DOLLAR;
                depth_reg    <= DEP_W'(1);
                finished_reg <= 1'b0;
            end
            pend_reg <= last_of_string && (in_symbol != CH_DOLLAR);
            cnt_reg  <= '0;
        end
        else if (cmd.step)
        begin
            cnt_reg   <= cnt_reg + CNT_W'(1);
            depth_reg <= depth_next;
            if (do_push)
            begin
                top_reg <= cur_reg;
            end
            else if (do_pop)
            begin
                // the bottom marker never sits in the array
                top_reg <= (depth_reg == DEP_W'(2)) ? CH_DOLLAR :
                           stack_mem[depth_m2[IDX_W-1:0]];
            end
            if (do_fin)
            begin
                finished_reg <= 1'b1;
            end
            if (run_end && !do_fin && pend_reg)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg <= in_symbol;
        end
        else if (cmd.step && run_end && !do_fin && pend_reg)
        begin
            cur_reg <= CH_DOLLAR;
        end
        if (cmd.find)
        begin
            row_hit_reg <= row_hit;
            col_hit_reg <= col_hit;
            row_idx_reg <= row_idx;
            col_idx_reg <= col_idx;
        end
        if (cmd.step)
        begin
            out_act_reg   <= act;
            out_sym_reg   <= act_sym;
            out_depth_reg <= DOUT_W'(depth_next);
            out_last_reg  <= run_end && (do_fin || !pend_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(OUT_TDATA_W - DOUT_W - SYM_W - ACT_W)'(0),
                       out_depth_reg, out_sym_reg, out_act_reg};

endmodule

// File: hw/rtl/operator_precedence_shift_reduce.sv
// ----------------------------------------------------------------------------
// operator_precedence_shift_reduce
// Operator-precedence shift-reduce recogniser on a configurable symbol stack.
// ----------------------------------------------------------------------------
// Input words carry one symbol on s_tdata; s_tuser opens a new string and
// s_tlast closes it with an implied end marker. Each word yields zero or more
// result words (shift, reduce, accept or an error) on the m_ side, the last
// one marked by m_tlast. The terminal list and precedence table are loaded
// through the cfg_ write port; the user must load them while the block is
// idle, which the block itself does not enforce. A word is taken in the idle
// state; every result then needs a terminal lookup and a stack step, and the
// first result of a word is presented on m_tvalid from the output register
// after the lookup and step states. The run of reductions each symbol causes
// sets the average rate. A new word is taken only once the previous is done.
// Once a string has been accepted or has failed, further words drop without
// results until one arrives with s_tuser high.
// Results go through a one-word output register; while it is full and m_tready
// is low the step stalls until that register drains, and new input waits meanwhile.
// Reset empties the stack to the bottom marker, clears the table to invalid
// relations and the terminal count to zero.
// ----------------------------------------------------------------------------
module operator_precedence_shift_reduce
    import opsr_pkg::*;
#(
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int MAX_TERMINALS = MAX_TERM_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SYM_W-1:0]       s_tdata,   // in_symbol
    input  logic                   s_tuser,   // first_of_string
    input  logic                   s_tlast,   // last_of_string
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // action, acted_symbol, depth_after
    output logic                   m_tlast,   // run_last
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DAT_W-1:0]   cfg_data
);

    opsr_cmd_t         cmd;
    opsr_sts_t         sts;
    logic [SYM_W-1:0]  top_sym;
    logic [SYM_W-1:0]  cur_sym;
    logic              row_hit;
    logic              col_hit;
    logic [TIDX_W-1:0] row_idx;
    logic [TIDX_W-1:0] col_idx;
    logic [TIDX_W-1:0] row_sel;
    logic [TIDX_W-1:0] col_sel;
    logic [2:0]        rel_code;

    opsr_cfg #(
        .MAX_TERMINALS (MAX_TERMINALS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .top_sym   (top_sym),
        .cur_sym   (cur_sym),
        .row_hit   (row_hit),
        .row_idx   (row_idx),
        .col_hit   (col_hit),
        .col_idx   (col_idx),
        .row_sel   (row_sel),
        .col_sel   (col_sel),
        .rel_code  (rel_code)
    );

    opsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    opsr_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_symbol       (s_tdata),
        .first_of_string (s_tuser),
        .last_of_string  (s_tlast),
        .top_sym         (top_sym),
        .cur_sym         (cur_sym),
        .row_hit         (row_hit),
        .row_idx         (row_idx),
        .col_hit         (col_hit),
        .col_idx         (col_idx),
        .row_sel         (row_sel),
        .col_sel         (col_sel),
        .rel_code        (rel_code),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast)
    );

endmodule
